FILE: design/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg - shared types and constants of the bilinear texel filter
// Widths of texels, fractions, corner weights and lane products.
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int CH_W         = 8;   // one color channel
	localparam int NUM_CH       = 4;   // A, R, G, B
	localparam int NUM_CORNERS  = 4;   // TL, TR, BR, BL
	localparam int TEXEL_W      = CH_W * NUM_CH;
	localparam int FRAC_W       = 8;
	localparam int WEIGHT_W     = 17;  // corner weight, up to 65536
	localparam int PROD_W       = CH_W + WEIGHT_W;
	localparam int SUM_W        = PROD_W + 2;
	localparam int WEIGHT_SHIFT = 16;  // weights sum to 1 << 16

	// smoothstep coefficient: f*f*(768 - 2f) >> 16
	localparam logic [9:0] SMOOTH_K = 10'd768;
	localparam int SMOOTH_SQ_W   = 2 * FRAC_W;
	localparam int SMOOTH_PROD_W = SMOOTH_SQ_W + 10;

	// corner order inside packed vectors
	localparam int CORNER_TL = 0;
	localparam int CORNER_TR = 1;
	localparam int CORNER_BR = 2;
	localparam int CORNER_BL = 3;

	// channel order inside a texel (byte index)
	localparam int CH_ALPHA = 3;

	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef logic [TEXEL_W-1:0]                        texel_t;
	typedef logic [NUM_CORNERS-1:0][TEXEL_W-1:0]       texel_vec_t;
	typedef logic [NUM_CORNERS-1:0][CH_W-1:0]          chan_vec_t;
	typedef logic [NUM_CORNERS-1:0][WEIGHT_W-1:0]      weight_vec_t;
	typedef logic [NUM_CORNERS-1:0][PROD_W-1:0]        prod_vec_t;
	typedef logic [NUM_CH-1:0][NUM_CORNERS-1:0][PROD_W-1:0] lane_prod_t;

	// stage enables of the two-stage fraction unit
	typedef struct packed {
		logic s1;
		logic s2;
	} frac_en_t;

endpackage

FILE: design/bat_in_if.sv
// ----------------------------------------------------------------------------
// bat_in_if - input channel of the bilinear texel filter
// Four corner texels and two 8-bit fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bat_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] texel_top_left;
	logic [31:0] texel_top_right;
	logic [31:0] texel_bottom_right;
	logic [31:0] texel_bottom_left;
	logic [7:0]  frac_x;
	logic [7:0]  frac_y;

	modport source (
		output valid, texel_top_left, texel_top_right, texel_bottom_right,
		       texel_bottom_left, frac_x, frac_y,
		input  ready
	);
	modport sink (
		input  valid, texel_top_left, texel_top_right, texel_bottom_right,
		       texel_bottom_left, frac_x, frac_y,
		output ready
	);
endinterface

FILE: design/bat_out_if.sv
// ----------------------------------------------------------------------------
// bat_out_if - result channel of the bilinear texel filter
// Filtered ARGB color and blend flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bat_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] filtered_color;
	logic        needs_blend;

	modport source (
		output valid, filtered_color, needs_blend,
		input  ready
	);
	modport sink (
		input  valid, filtered_color, needs_blend,
		output ready
	);
endinterface

FILE: design/bilinear_argb_texel_filter.sv
// ----------------------------------------------------------------------------
// bilinear_argb_texel_filter - bilinear ARGB8888 texel filter
// Blends four neighboring texels by 8-bit subtexel fractions.
// ----------------------------------------------------------------------------
// Takes one transaction per clock on "texels" while the result side does not
// stall, and returns one filtered color per transaction on "result", in order.
// Pipeline: s1 registers texels and squares each fraction, s2 applies the
// optional smoothstep (cfg_wdata bit written with cfg_we, reset to linear), s3
// forms the four corner weights, s4 runs four channel lanes (A, R, G, B) that
// each multiply the corner bytes by the weights, s5 merges each lane's
// products, shifts by 16 and registers the result. Stages advance
// independently, so bubbles collapse and a new transaction is taken while a
// finished result waits to be taken, as long as an earlier stage is empty. When
// all four alphas are 255 the output alpha is 255 and needs_blend is low.
// Change the smoothing mode only while no transaction is in flight.
// ----------------------------------------------------------------------------
module bilinear_argb_texel_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	bat_in_if.sink     texels,
	bat_out_if.source  result
);
	import bat_pkg::*;

	// configuration
	logic smoothing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_q <= 1'b0;
		end else if (cfg_we) begin
			smoothing_q <= cfg_wdata;
		end
	end

	// per-stage valid and enables: a stage loads when it is empty or its
	// contents move on in the same clock
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = ~valid_s5 | result.ready;
	assign en_s4 = ~valid_s4 | en_s5;
	assign en_s3 = ~valid_s3 | en_s4;
	assign en_s2 = ~valid_s2 | en_s3;
	assign en_s1 = ~valid_s1 | en_s2;

	assign texels.ready = en_s1;
	assign result.valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= texels.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// texel payload travels alongside the fraction and weight stages
	texel_vec_t texel_in, texel_s1, texel_s2, texel_s3;
	logic       opaque_in, opaque_s1, opaque_s2, opaque_s3, opaque_s4;

	assign texel_in[CORNER_TL] = texels.texel_top_left;
	assign texel_in[CORNER_TR] = texels.texel_top_right;
	assign texel_in[CORNER_BR] = texels.texel_bottom_right;
	assign texel_in[CORNER_BL] = texels.texel_bottom_left;

	// opaque when every corner alpha is 255
	assign opaque_in = (texels.texel_top_left[CH_ALPHA*CH_W +: CH_W]
	                  & texels.texel_top_right[CH_ALPHA*CH_W +: CH_W]
	                  & texels.texel_bottom_right[CH_ALPHA*CH_W +: CH_W]
	                  & texels.texel_bottom_left[CH_ALPHA*CH_W +: CH_W]) == CH_MAX;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			texel_s1  <= texel_in;
			opaque_s1 <= opaque_in;
		end
		if (en_s2) begin
			texel_s2  <= texel_s1;
			opaque_s2 <= opaque_s1;
		end
		if (en_s3) begin
			texel_s3  <= texel_s2;
			opaque_s3 <= opaque_s2;
		end
		if (en_s4) begin
			opaque_s4 <= opaque_s3;
		end
	end

	// s1..s2: fraction shaping, one unit per axis
	frac_en_t          frac_en;
	logic [FRAC_W-1:0] fx_s2, fy_s2;

	assign frac_en.s1 = en_s1;
	assign frac_en.s2 = en_s2;

	bat_frac u_frac_x (
		.clk     (clk),
		.en      (frac_en),
		.mode    (smoothing_q),
		.frac    (texels.frac_x),
		.frac_s2 (fx_s2)
	);

	bat_frac u_frac_y (
		.clk     (clk),
		.en      (frac_en),
		.mode    (smoothing_q),
		.frac    (texels.frac_y),
		.frac_s2 (fy_s2)
	);

	// s3: corner weights
	weight_vec_t weight_s3;

	bat_weights u_weights (
		.clk       (clk),
		.en        (en_s3),
		.fx        (fx_s2),
		.fy        (fy_s2),
		.weight_s3 (weight_s3)
	);

	// s4: one lane per channel
	lane_prod_t lane_prod_s4;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		chan_vec_t chan;

		for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
			assign chan[k] = texel_s3[k][c*CH_W +: CH_W];
		end

		bat_lane u_lane (
			.clk     (clk),
			.en      (en_s4),
			.chan    (chan),
			.weight  (weight_s3),
			.prod_s4 (lane_prod_s4[c])
		);
	end

	// s5: merge and output register
	bat_merge u_merge (
		.clk       (clk),
		.en        (en_s5),
		.lane_prod (lane_prod_s4),
		.opaque    (opaque_s4),
		.color_s5  (result.filtered_color),
		.blend_s5  (result.needs_blend)
	);

	// ---------------------------------------------------------------- checks
	logic [WEIGHT_W+1:0] weight_sum;

	assign weight_sum = {2'b00, weight_s3[CORNER_TL]} + {2'b00, weight_s3[CORNER_TR]}
	                  + {2'b00, weight_s3[CORNER_BR]} + {2'b00, weight_s3[CORNER_BL]};

	// corner weights always partition unity
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> weight_sum == ((WEIGHT_W+2)'(1) << WEIGHT_SHIFT))
		else $error("corner weights do not sum to 65536");

	// an opaque result carries full alpha
	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.needs_blend |->
			result.filtered_color[CH_ALPHA*CH_W +: CH_W] == CH_MAX)
		else $error("opaque result without full alpha");

	// a new result only appears when s4 held a transaction
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s5) |-> $past(valid_s4))
		else $error("result valid without a transaction in s4");

endmodule

FILE: design/bat_frac.sv
// ----------------------------------------------------------------------------
// bat_frac - fraction shaping unit
// Two stages: square, then smoothstep scale and mode select.
// ----------------------------------------------------------------------------
module bat_frac (
	input  logic                     clk,
	input  bat_pkg::frac_en_t        en,
	input  logic                     mode,
	input  logic [bat_pkg::FRAC_W-1:0] frac,
	output logic [bat_pkg::FRAC_W-1:0] frac_s2
);
	import bat_pkg::*;

	logic [FRAC_W-1:0]        frac_s1;
	logic [SMOOTH_SQ_W-1:0]   sq_s1;
	logic                     mode_s1;
	logic [9:0]               coef;
	logic [SMOOTH_PROD_W-1:0] prod;
	logic [FRAC_W-1:0]        smooth;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			frac_s1 <= frac;
			mode_s1 <= mode;
			sq_s1   <= {{FRAC_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, frac};
		end
	end

	assign coef   = SMOOTH_K - {1'b0, frac_s1, 1'b0};
	assign prod   = {10'd0, sq_s1} * {{SMOOTH_SQ_W{1'b0}}, coef};
	// result never exceeds 255, upper bits are zero
	assign smooth = prod[WEIGHT_SHIFT +: FRAC_W];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			frac_s2 <= mode_s1 ? smooth : frac_s1;
		end
	end

endmodule

FILE: design/bat_weights.sv
// ----------------------------------------------------------------------------
// bat_weights - corner weight generator
// Forms the four 17-bit bilinear weights from the shaped fractions.
// ----------------------------------------------------------------------------
module bat_weights (
	input  logic                       clk,
	input  logic                       en,
	input  logic [bat_pkg::FRAC_W-1:0] fx,
	input  logic [bat_pkg::FRAC_W-1:0] fy,
	output bat_pkg::weight_vec_t       weight_s3
);
	import bat_pkg::*;

	localparam int OP_W = FRAC_W + 1;

	logic [OP_W-1:0]   ax, ay, nx, ny;
	logic [2*OP_W-1:0] p_tl, p_tr, p_br, p_bl;

	assign ax = {1'b0, fx};
	assign ay = {1'b0, fy};
	assign nx = (OP_W'(1) << FRAC_W) - ax;
	assign ny = (OP_W'(1) << FRAC_W) - ay;

	assign p_tl = {{OP_W{1'b0}}, nx} * {{OP_W{1'b0}}, ny};
	assign p_tr = {{OP_W{1'b0}}, ax} * {{OP_W{1'b0}}, ny};
	assign p_br = {{OP_W{1'b0}}, ax} * {{OP_W{1'b0}}, ay};
	assign p_bl = {{OP_W{1'b0}}, nx} * {{OP_W{1'b0}}, ay};

	always_ff @(posedge clk) begin
		if (en) begin
			weight_s3[CORNER_TL] <= p_tl[WEIGHT_W-1:0];
			weight_s3[CORNER_TR] <= p_tr[WEIGHT_W-1:0];
			weight_s3[CORNER_BR] <= p_br[WEIGHT_W-1:0];
			weight_s3[CORNER_BL] <= p_bl[WEIGHT_W-1:0];
		end
	end

endmodule

FILE: design/bat_lane.sv
// ----------------------------------------------------------------------------
// bat_lane - one color channel lane
// Multiplies the channel byte of each corner by its weight.
// ----------------------------------------------------------------------------
module bat_lane (
	input  logic                 clk,
	input  logic                 en,
	input  bat_pkg::chan_vec_t   chan,
	input  bat_pkg::weight_vec_t weight,
	output bat_pkg::prod_vec_t   prod_s4
);
	import bat_pkg::*;

	prod_vec_t prod;

	always_comb begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			prod[k] = {{WEIGHT_W{1'b0}}, chan[k]} * {{CH_W{1'b0}}, weight[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= prod;
		end
	end

endmodule

FILE: design/bat_merge.sv
// ----------------------------------------------------------------------------
// bat_merge - lane merge and output register
// Sums each lane, drops the 16 fraction bits, forces opaque alpha.
// ----------------------------------------------------------------------------
module bat_merge (
	input  logic                clk,
	input  logic                en,
	input  bat_pkg::lane_prod_t lane_prod,
	input  logic                opaque,
	output bat_pkg::texel_t     color_s5,
	output logic                blend_s5
);
	import bat_pkg::*;

	logic [NUM_CH-1:0][SUM_W-1:0] acc;
	texel_t                       color;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc[c] = {2'b00, lane_prod[c][CORNER_TL]} + {2'b00, lane_prod[c][CORNER_TR]}
			       + {2'b00, lane_prod[c][CORNER_BR]} + {2'b00, lane_prod[c][CORNER_BL]};
			color[c*CH_W +: CH_W] = acc[c][WEIGHT_SHIFT +: CH_W];
		end
		if (opaque) begin
			color[CH_ALPHA*CH_W +: CH_W] = CH_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s5 <= color;
			blend_s5 <= ~opaque;
		end
	end

endmodule
